// File: rtl/dwpb_pkg.sv
// Shared types, constants and register codes of the differential wheel PI balancer.
`default_nettype none

package dwpb_pkg;

  // Default widths of the stored positions and of the error integrator.
  localparam int POSITION_BITS_DEF   = 16;
  localparam int INTEGRATOR_BITS_DEF = 24;

  // Gains and the PWM period are 16-bit multipliers worked one bit per step.
  localparam int GAIN_BITS = 16;
  localparam int CNT_W     = $clog2(GAIN_BITS);

  // Register file geometry.
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int REG_W   = 3;

  // Configuration reset values.
  localparam logic        [15:0] PROP_GAIN_RST   = 16'd0;
  localparam logic        [15:0] INTEG_GAIN_RST  = 16'd0;
  localparam logic signed [23:0] INTEG_UPPER_RST = 24'sh7FFFFF;
  localparam logic signed [23:0] INTEG_LOWER_RST = 24'sh800000;
  localparam logic        [15:0] DUTY_UPPER_RST  = 16'hFFFF;
  localparam logic        [15:0] DUTY_LOWER_RST  = 16'h0000;
  localparam logic        [15:0] PWM_PERIOD_RST  = 16'd1199;

  typedef enum logic [REG_W-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_INTEG_UPPER = 3'd2,
    REG_INTEG_LOWER = 3'd3,
    REG_DUTY_UPPER  = 3'd4,
    REG_DUTY_LOWER  = 3'd5,
    REG_PWM_PERIOD  = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INTEG,
    ST_CORR,
    ST_DUTY,
    ST_PWM,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [15:0] left_position;
    logic signed [15:0] right_position;
    logic        [15:0] left_ref_in;
    logic        [15:0] right_ref_in;
  } in_item_t;

  typedef struct packed {
    logic [15:0] left_ref_out;
    logic [15:0] right_ref_out;
    logic [15:0] left_compare;
    logic [15:0] right_compare;
  } out_item_t;

  typedef struct packed {
    logic        [15:0] prop_gain;
    logic        [15:0] integ_gain;
    logic signed [23:0] integ_upper;
    logic signed [23:0] integ_lower;
    logic        [15:0] duty_upper;
    logic        [15:0] duty_lower;
    logic        [15:0] pwm_period;
  } cfg_t;

  typedef struct packed {
    logic             ready;
    logic             integ_en;
    logic             acc_clr;
    logic             corr_step;
    logic             duty_en;
    logic             pwm_step;
    logic             out_load;
    logic [CNT_W-1:0] bit_idx;
  } ctrl_t;

endpackage

`default_nettype wire

// File: rtl/differential_wheel_pi_balancer.sv
// Top level of the differential wheel PI balancer: datapath, state and channel registers.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   dwpb_pkg::in_item_t
//   out      output     out_valid/out_stall dwpb_pkg::out_item_t
//   cfg      input      psel/penable/pready dwpb_pkg::cfg_t via paddr/pwdata/prdata
//
// A new item is taken only once the sequencer is back in idle, after the last result has
// been loaded into the output register. Each item passes through the shared shift-add
// unit: 16 steps for the two gain products and 16 steps for both PWM products.
// Reset clears the stored positions and the integrator and restores the register defaults.
// A result waits in the output register; if it is still stalled when the next one is
// ready, the sequencer holds in its last phase until the transfer out completes.
`default_nettype none

module differential_wheel_pi_balancer #(
  parameter int POSITION_BITS   = dwpb_pkg::POSITION_BITS_DEF,
  parameter int INTEGRATOR_BITS = dwpb_pkg::INTEGRATOR_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire dwpb_pkg::in_item_t           in_data,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output dwpb_pkg::out_item_t               out_data,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [dwpb_pkg::PADDR_W-1:0] paddr,
  input  wire logic [dwpb_pkg::PDATA_W-1:0] pwdata,
  output logic      [dwpb_pkg::PDATA_W-1:0] prdata,
  output logic                              pready
);

  localparam int PX    = (POSITION_BITS > 16) ? POSITION_BITS : 16;
  localparam int EW    = POSITION_BITS + 1;
  localparam int SM1   = (INTEGRATOR_BITS > EW) ? INTEGRATOR_BITS : EW;
  localparam int SW    = ((SM1 > 24) ? SM1 : 24) + 1;
  localparam int CW    = SM1 + 18;
  localparam int ACC_W = (CW > 64) ? CW : 64;
  localparam int DW    = ACC_W + 1;

  localparam logic signed [SW-1:0] IMAX = SW'((64'sd1 <<< (INTEGRATOR_BITS - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] IMIN = -IMAX - SW'(1);

  dwpb_pkg::cfg_t  cfg;
  dwpb_pkg::ctrl_t ctrl;

  logic                              in_accept;
  logic                              out_free;

  logic        [POSITION_BITS-1:0]   prev_left_position;
  logic        [POSITION_BITS-1:0]   prev_right_position;
  logic signed [INTEGRATOR_BITS-1:0] error_integral;
  logic signed [EW-1:0]              err;
  logic        [15:0]                lref_q;
  logic        [15:0]                rref_q;
  logic        [15:0]                lout_q;
  logic        [15:0]                rout_q;
  logic        [ACC_W-1:0]           acc;

  logic signed [PX-1:0]              lpos_x;
  logic signed [PX-1:0]              rpos_x;
  logic        [POSITION_BITS-1:0]   lpos;
  logic        [POSITION_BITS-1:0]   rpos;
  logic        [POSITION_BITS-1:0]   dl;
  logic        [POSITION_BITS-1:0]   dr;
  logic signed [EW-1:0]              err_next;

  logic signed [SW-1:0]              integ_sum;
  logic signed [SW-1:0]              integ_hi;
  logic signed [SW-1:0]              integ_lo;
  logic signed [SW-1:0]              integ_c1;
  logic signed [SW-1:0]              integ_c2;
  logic signed [SW-1:0]              integ_c3;

  logic        [ACC_W-1:0]           op_a;
  logic        [ACC_W-1:0]           op_b;
  logic                              sel_a;
  logic                              sel_b;
  logic        [ACC_W-1:0]           step_sum;

  logic signed [ACC_W-1:0]           corr;
  logic signed [DW-1:0]              corr_w;
  logic signed [DW-1:0]              duty_hi;
  logic signed [DW-1:0]              duty_lo;
  logic signed [DW-1:0]              lnew;
  logic signed [DW-1:0]              rnew;
  logic signed [DW-1:0]              lc1;
  logic signed [DW-1:0]              rc1;
  logic signed [DW-1:0]              lc2;
  logic signed [DW-1:0]              rc2;

  dwpb_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dwpb_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .out_free  (out_free),
    .ctrl      (ctrl)
  );

  dwpb_step_unit #(
    .ACC_W (ACC_W)
  ) u_step (
    .acc   (acc),
    .op_a  (op_a),
    .op_b  (op_b),
    .sel_a (sel_a),
    .sel_b (sel_b),
    .sum   (step_sum)
  );

  assign in_stall  = !ctrl.ready;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Positions are sign-extended from 16 bits, then wrapped to the stored width.
  assign lpos_x   = PX'(in_data.left_position);
  assign rpos_x   = PX'(in_data.right_position);
  assign lpos     = lpos_x[POSITION_BITS-1:0];
  assign rpos     = rpos_x[POSITION_BITS-1:0];
  assign dl       = lpos - prev_left_position;
  assign dr       = rpos - prev_right_position;
  assign err_next = $signed({dl[POSITION_BITS-1], dl}) - $signed({dr[POSITION_BITS-1], dr});

  // Upper clamp first, then lower, then the integrator's own range.
  assign integ_sum = SW'(error_integral) + SW'(err);
  assign integ_hi  = SW'(cfg.integ_upper);
  assign integ_lo  = SW'(cfg.integ_lower);
  assign integ_c1  = (integ_sum > integ_hi) ? integ_hi : integ_sum;
  assign integ_c2  = (integ_c1 < integ_lo) ? integ_lo : integ_c1;
  assign integ_c3  = (integ_c2 > IMAX) ? IMAX : ((integ_c2 < IMIN) ? IMIN : integ_c2);

  // The correction phase runs both gain products at once; the PWM phase packs the right
  // reference 32 bits above the left one so that one product yields both compare values.
  always_comb begin
    if (ctrl.pwm_step) begin
      op_a  = ACC_W'({rout_q, 16'd0, lout_q});
      op_b  = '0;
      sel_a = cfg.pwm_period[ctrl.bit_idx];
      sel_b = 1'b0;
    end else begin
      op_a  = ACC_W'(err);
      op_b  = ACC_W'(error_integral);
      sel_a = cfg.prop_gain[ctrl.bit_idx];
      sel_b = cfg.integ_gain[ctrl.bit_idx];
    end
  end

  assign corr    = $signed(acc) >>> 8;
  assign corr_w  = DW'(corr);
  assign duty_hi = DW'($signed({1'b0, cfg.duty_upper}));
  assign duty_lo = DW'($signed({1'b0, cfg.duty_lower}));
  assign lnew    = DW'($signed({1'b0, lref_q})) - corr_w;
  assign rnew    = DW'($signed({1'b0, rref_q})) + corr_w;
  assign lc1     = (lnew > duty_hi) ? duty_hi : lnew;
  assign rc1     = (rnew > duty_hi) ? duty_hi : rnew;
  assign lc2     = (lc1 < duty_lo) ? duty_lo : lc1;
  assign rc2     = (rc1 < duty_lo) ? duty_lo : rc1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_left_position  <= '0;
      prev_right_position <= '0;
      error_integral      <= '0;
      out_valid           <= 1'b0;
    end else begin
      if (in_accept) begin
        prev_left_position  <= lpos;
        prev_right_position <= rpos;
      end
      if (ctrl.integ_en) begin
        error_integral <= integ_c3[INTEGRATOR_BITS-1:0];
      end
      if (ctrl.out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      err    <= err_next;
      lref_q <= in_data.left_ref_in;
      rref_q <= in_data.right_ref_in;
    end
    if (ctrl.acc_clr) begin
      acc <= '0;
    end else if (ctrl.corr_step || ctrl.pwm_step) begin
      acc <= step_sum;
    end
    if (ctrl.duty_en) begin
      lout_q <= lc2[15:0];
      rout_q <= rc2[15:0];
    end
    if (ctrl.out_load) begin
      out_data.left_ref_out  <= lout_q;
      out_data.right_ref_out <= rout_q;
      out_data.left_compare  <= acc[31:16];
      out_data.right_compare <= acc[63:48];
    end
  end

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> in_stall)
    else $error("block took a new item while one is still in work");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !ctrl.out_load)
    else $error("stalled result overwritten");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    ctrl.out_load |=> out_valid)
    else $error("result loaded without valid");

  a_duty_in_range: assert property (@(posedge clk) disable iff (rst)
    (ctrl.duty_en && cfg.duty_lower <= cfg.duty_upper) |=>
      (lout_q >= $past(cfg.duty_lower) && lout_q <= $past(cfg.duty_upper) &&
       rout_q >= $past(cfg.duty_lower) && rout_q <= $past(cfg.duty_upper)))
    else $error("clamped duty outside its limits");

endmodule

`default_nettype wire

// File: rtl/dwpb_cfg_regs.sv
// Configuration register file with an APB-style write and read port.
`default_nettype none

module dwpb_cfg_regs (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [dwpb_pkg::PADDR_W-1:0] paddr,
  input  wire logic [dwpb_pkg::PDATA_W-1:0] pwdata,
  output logic      [dwpb_pkg::PDATA_W-1:0] prdata,
  output logic                              pready,
  output dwpb_pkg::cfg_t                    cfg
);

  dwpb_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx    = dwpb_pkg::reg_idx_t'(paddr[dwpb_pkg::PADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain   <= dwpb_pkg::PROP_GAIN_RST;
      cfg.integ_gain  <= dwpb_pkg::INTEG_GAIN_RST;
      cfg.integ_upper <= dwpb_pkg::INTEG_UPPER_RST;
      cfg.integ_lower <= dwpb_pkg::INTEG_LOWER_RST;
      cfg.duty_upper  <= dwpb_pkg::DUTY_UPPER_RST;
      cfg.duty_lower  <= dwpb_pkg::DUTY_LOWER_RST;
      cfg.pwm_period  <= dwpb_pkg::PWM_PERIOD_RST;
    end else if (wr_en) begin
      case (idx)
        dwpb_pkg::REG_PROP_GAIN:   cfg.prop_gain   <= pwdata[15:0];
        dwpb_pkg::REG_INTEG_GAIN:  cfg.integ_gain  <= pwdata[15:0];
        dwpb_pkg::REG_INTEG_UPPER: cfg.integ_upper <= pwdata[23:0];
        dwpb_pkg::REG_INTEG_LOWER: cfg.integ_lower <= pwdata[23:0];
        dwpb_pkg::REG_DUTY_UPPER:  cfg.duty_upper  <= pwdata[15:0];
        dwpb_pkg::REG_DUTY_LOWER:  cfg.duty_lower  <= pwdata[15:0];
        dwpb_pkg::REG_PWM_PERIOD:  cfg.pwm_period  <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      dwpb_pkg::REG_PROP_GAIN:   prdata = {16'd0, cfg.prop_gain};
      dwpb_pkg::REG_INTEG_GAIN:  prdata = {16'd0, cfg.integ_gain};
      dwpb_pkg::REG_INTEG_UPPER: prdata = {{8{cfg.integ_upper[23]}}, cfg.integ_upper};
      dwpb_pkg::REG_INTEG_LOWER: prdata = {{8{cfg.integ_lower[23]}}, cfg.integ_lower};
      dwpb_pkg::REG_DUTY_UPPER:  prdata = {16'd0, cfg.duty_upper};
      dwpb_pkg::REG_DUTY_LOWER:  prdata = {16'd0, cfg.duty_lower};
      dwpb_pkg::REG_PWM_PERIOD:  prdata = {16'd0, cfg.pwm_period};
      default:                   prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/dwpb_step_unit.sv
// Shared shift-add step: doubles the accumulator and adds the selected multiplicands.
`default_nettype none

module dwpb_step_unit #(
  parameter int ACC_W = 64
) (
  input  wire logic [ACC_W-1:0] acc,
  input  wire logic [ACC_W-1:0] op_a,
  input  wire logic [ACC_W-1:0] op_b,
  input  wire logic             sel_a,
  input  wire logic             sel_b,
  output logic      [ACC_W-1:0] sum
);

  logic [ACC_W-1:0] add_a;
  logic [ACC_W-1:0] add_b;

  assign add_a = sel_a ? op_a : '0;
  assign add_b = sel_b ? op_b : '0;
  assign sum   = {acc[ACC_W-2:0], 1'b0} + add_a + add_b;

endmodule

`default_nettype wire

// File: rtl/dwpb_seq.sv
// Sequencer that steps one item through the integrator, correction, duty and PWM phases.
`default_nettype none

module dwpb_seq (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_accept,
  input  wire logic            out_free,
  output dwpb_pkg::ctrl_t      ctrl
);

  dwpb_pkg::state_t               state;
  dwpb_pkg::state_t               state_next;
  logic [dwpb_pkg::CNT_W-1:0]     count;
  logic                           count_zero;

  assign count_zero = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dwpb_pkg::ST_IDLE;
      count <= dwpb_pkg::CNT_W'(dwpb_pkg::GAIN_BITS - 1);
    end else begin
      state <= state_next;
      if (state == dwpb_pkg::ST_CORR || state == dwpb_pkg::ST_PWM) begin
        count <= count - 1'b1;
      end else begin
        count <= dwpb_pkg::CNT_W'(dwpb_pkg::GAIN_BITS - 1);
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      dwpb_pkg::ST_IDLE: begin
        if (in_accept) state_next = dwpb_pkg::ST_INTEG;
      end
      dwpb_pkg::ST_INTEG: state_next = dwpb_pkg::ST_CORR;
      dwpb_pkg::ST_CORR: begin
        if (count_zero) state_next = dwpb_pkg::ST_DUTY;
      end
      dwpb_pkg::ST_DUTY: state_next = dwpb_pkg::ST_PWM;
      dwpb_pkg::ST_PWM: begin
        if (count_zero) state_next = dwpb_pkg::ST_DONE;
      end
      dwpb_pkg::ST_DONE: begin
        if (out_free) state_next = dwpb_pkg::ST_IDLE;
      end
      default: state_next = dwpb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl         = '0;
    ctrl.bit_idx = count;
    case (state)
      dwpb_pkg::ST_IDLE:  ctrl.ready = 1'b1;
      dwpb_pkg::ST_INTEG: begin
        ctrl.integ_en = 1'b1;
        ctrl.acc_clr  = 1'b1;
      end
      dwpb_pkg::ST_CORR:  ctrl.corr_step = 1'b1;
      dwpb_pkg::ST_DUTY: begin
        ctrl.duty_en = 1'b1;
        ctrl.acc_clr = 1'b1;
      end
      dwpb_pkg::ST_PWM:   ctrl.pwm_step = 1'b1;
      dwpb_pkg::ST_DONE:  ctrl.out_load = out_free;
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire
